/* design/pltu_pkg.sv */
// Package for the pin listener table: request/event item types, opcodes,
// settings-byte layout and small helpers. No dependencies.
`default_nettype none

package pltu_pkg;

  localparam int unsigned TableEntriesDefault = 32;
  localparam int unsigned ResultCap = 32;
  localparam int unsigned CapW = $clog2(ResultCap + 1);

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic KIND_ANALOG  = 1'b0;
  localparam logic KIND_DIGITAL = 1'b1;

  // settings byte layout
  localparam int unsigned ACT_BIT = 7;
  localparam int unsigned ANA_BIT = 6;
  localparam int unsigned LVL_BIT = 5;
  localparam int unsigned LOC_BIT = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  pin;
    logic        enable;
    logic        analog_mode;
    logic [2:0]  exponent;
    logic        from_local;
    logic [7:0]  tick_count;
    logic [63:0] pin_levels;
  } cmd_item_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] out_pin;
    logic       level;
    logic       last;
  } evt_item_t;

  typedef struct packed {
    logic [7:0] settings;
    logic [5:0] pin;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] pin;
    logic       level;
  } result_t;

  // scan side -> result queue
  typedef struct packed {
    logic    push;
    logic    close;
    result_t item;
  } rq_ctl_t;

  function automatic logic tick_due(logic [7:0] tick, logic [2:0] e);
    logic [7:0] m;
    m = 8'((9'd1 << e) - 9'd1);
    return (tick & m) == 8'd0;
  endfunction

  function automatic logic [7:0] settings_byte(logic en, logic ana, logic loc,
                                               logic [2:0] e);
    return {en, ana, 1'b0, loc, 1'b0, e};
  endfunction

endpackage

`default_nettype wire

/* design/pltu_stream_if.sv */
// Valid/ready stream interface used by both channels of the pin listener
// table. Payload type is set per instance.
`default_nettype none

interface pltu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/pltu_result_queue.sv */
// Result staging for tick scans: one pending slot plus the output register.
// The pending slot lets the final event be tagged last. Uses pltu_pkg.
`default_nettype none

module pltu_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  pltu_pkg::rq_ctl_t ctl,
  output logic              room,
  pltu_stream_if.source     evt
);
  import pltu_pkg::*;

  logic      pend_vld;
  result_t   pend;
  logic      out_vld;
  evt_item_t out_q;
  logic      out_free;
  logic      out_load;

  assign out_free = !out_vld || evt.ready;
  assign room = !pend_vld || out_free;
  // the held event moves out on a new push or on the tick's close
  assign out_load = pend_vld && out_free && (ctl.push || ctl.close);

  assign evt.valid = out_vld;
  assign evt.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      out_vld <= out_load || (out_vld && !evt.ready);
      if (ctl.push && room) begin
        pend_vld <= 1'b1;
        pend     <= ctl.item;
        if (pend_vld) begin
          out_q <= {pend.kind, pend.pin, pend.level, 1'b0};
        end
      end else if (ctl.close && pend_vld && out_free) begin
        // flush the held event as the final one of the tick
        pend_vld <= 1'b0;
        out_q    <= {pend.kind, pend.pin, pend.level, 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

/* design/pin_listener_table_unit.sv */
// Pin listener table: request decode, table memory and entry scan.
// Uses pltu_pkg, pltu_stream_if and pltu_result_queue.
//
//   channel | dir | payload     | accepted when
//   --------+-----+-------------+---------------------------
//   cmd     | in  | cmd_item_t  | cmd.valid && cmd.ready
//   evt     | out | evt_item_t  | evt.valid && evt.ready
//
// Every set, tick or clear request scans each table entry once from the
// single-port-read table memory, one entry a cycle while a tick is not
// stalled on evt.ready. A no-op request is taken without a scan. Reset
// clears the table at once through per-entry valid bits; no clearing pass.
// cmd.ready is high only between requests; a finished event may still sit
// in the output register then.
`default_nettype none

module pin_listener_table_unit #(
  parameter int unsigned TABLE_ENTRIES = pltu_pkg::TableEntriesDefault
) (
  input  logic          clk,
  input  logic          rst,
  pltu_stream_if.sink   cmd,
  pltu_stream_if.source evt
);
  import pltu_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LastCnt = CW'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]     state;
  cmd_item_t      item;
  logic [CW-1:0]  ic;
  logic           s1_vld;
  logic [IW-1:0]  s1_idx;
  logic           found;
  logic [IW-1:0]  match_idx;
  logic           match_loc;
  logic           free_found;
  logic [IW-1:0]  free_idx;
  logic [CapW-1:0] res_cnt;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  entry_t                   rd_q;
  logic                     rd_vld_q;

  entry_t         cur;
  logic [7:0]     s;
  logic           due;
  logic           lvl;
  logic           hit;
  logic           emit;
  logic           stall;
  logic           rq_room;
  logic [IW-1:0]  ra;
  logic           we;
  logic [IW-1:0]  wa;
  entry_t         wd;
  logic           clr;
  logic [7:0]     mask;
  rq_ctl_t        rq_ctl;

  assign cmd.ready = (state == ST_IDLE);

  assign cur  = rd_vld_q ? rd_q : '0;
  assign s    = cur.settings;
  assign due  = s[ACT_BIT] && tick_due(item.tick_count, s[2:0]);
  assign lvl  = item.pin_levels[cur.pin];
  assign hit  = (state == ST_SCAN) && s1_vld && (item.op == OP_TICK) && due &&
                (s[ANA_BIT] || (lvl != s[LVL_BIT]));
  assign emit = hit && (res_cnt != CapW'(ResultCap));
  assign stall = emit && !rq_room;
  assign mask = settings_byte(item.enable, item.analog_mode, item.from_local,
                              item.exponent);

  // hold the read on the stalled entry so its data stays in rd_q
  assign ra = stall ? s1_idx : ic[IW-1:0];

  assign clr = (state == ST_SCAN) && s1_vld && (item.op == OP_CLEAR) && !s[LOC_BIT];

  always_comb begin
    we = 1'b0;
    wa = s1_idx;
    wd = cur;
    if (hit && !s[ANA_BIT] && !stall) begin
      we = 1'b1;
      wd.settings[LVL_BIT] = lvl;
    end else if (state == ST_FIN && item.op == OP_SET) begin
      wd = {mask, item.pin};
      if (found) begin
        wa = match_idx;
        we = !match_loc || item.from_local;
      end else begin
        wa = free_idx;
        we = free_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q     <= mem[ra];
    rd_vld_q <= vld[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (we) vld[wa] <= 1'b1;
      if (clr) vld[s1_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      s1_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            item       <= cmd.data;
            ic         <= '0;
            s1_vld     <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            res_cnt    <= '0;
            if (cmd.data.op != OP_NOP) state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            s1_vld <= (ic != LastCnt);
            s1_idx <= ic[IW-1:0];
            if (ic != LastCnt) ic <= ic + CW'(1);
            if (s1_vld) begin
              if (!found && cur.pin == item.pin) begin
                found     <= 1'b1;
                match_idx <= s1_idx;
                match_loc <= s[LOC_BIT];
              end
              if (!free_found && !s[ACT_BIT]) begin
                free_found <= 1'b1;
                free_idx   <= s1_idx;
              end
              if (emit) res_cnt <= res_cnt + CapW'(1);
            end
            if (ic == LastCnt && !s1_vld) state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (item.op != OP_TICK || rq_room) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    rq_ctl.push       = emit;
    rq_ctl.close      = (state == ST_FIN) && (item.op == OP_TICK);
    rq_ctl.item.kind  = s[ANA_BIT] ? KIND_ANALOG : KIND_DIGITAL;
    rq_ctl.item.pin   = cur.pin;
    rq_ctl.item.level = s[ANA_BIT] ? 1'b0 : lvl;
  end

  pltu_result_queue u_result_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rq_ctl),
    .room (rq_room),
    .evt  (evt)
  );

endmodule

`default_nettype wire

/* design/pltu_checker.sv */
// Port-level checks for the pin listener table, bound to the top level.
// Uses pltu_pkg.
`default_nettype none

module pltu_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_op,
  input logic       evt_valid,
  input logic       evt_ready,
  input logic       evt_kind,
  input logic [5:0] evt_pin,
  input logic       evt_level,
  input logic       evt_last
);
  import pltu_pkg::*;

  // a real request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op != OP_NOP) |=> !cmd_ready)
    else $error("cmd.ready high right after a request was taken");

  // between requests only the final event of a tick can be waiting
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    cmd_ready && evt_valid |-> evt_last)
    else $error("non-final event left over while idle");

  a_analog_level: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt_kind == KIND_ANALOG) |-> !evt_level)
    else $error("analog sample request with nonzero level");

  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_pin) && $stable(evt_kind)
      && $stable(evt_level) && $stable(evt_last))
    else $error("stalled event changed");

endmodule

bind pin_listener_table_unit pltu_checker u_pltu_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_op    (cmd.data.op),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_kind  (evt.data.kind),
  .evt_pin   (evt.data.out_pin),
  .evt_level (evt.data.level),
  .evt_last  (evt.data.last)
);

`default_nettype wire

/* tb/pltu_tb_pkg.sv */
`timescale 1ns / 1ps
// Listener table model and event scoreboard for the pin listener table bench.
// Depends on pltu_pkg for the request/event item types and settings-bit positions.

package pltu_tb_pkg;
  import pltu_pkg::*;

  localparam int unsigned Entries = TableEntriesDefault;

  class listener_table_model;
    logic [7:0] settings[Entries];
    logic [5:0] pins[Entries];
    int unsigned top_active;
    evt_item_t pending_events[$];
    int unsigned mismatches;

    function new();
      for (int k = 0; k < Entries; k++) begin
        settings[k] = '0;
        pins[k] = '0;
      end
      top_active = 0;
      mismatches = 0;
    endfunction

    // keeps the old index when nothing is active
    function void refresh_top();
      for (int k = 0; k < Entries; k++) begin
        if (settings[k][ACT_BIT]) top_active = k;
      end
    endfunction

    function void apply_set(cmd_item_t req);
      logic [7:0] s;
      int hit;
      int slot;
      s = {req.enable, req.analog_mode, 1'b0, req.from_local, 1'b0, req.exponent};
      hit = -1;
      slot = -1;
      // a pin match stops the search, even on an inactive entry
      for (int k = 0; k < Entries && hit < 0; k++) begin
        if (pins[k] == req.pin) hit = k;
      end
      if (hit >= 0) begin
        if (!settings[hit][LOC_BIT] || req.from_local) settings[hit] = s;
      end else begin
        for (int k = 0; k < Entries && slot < 0; k++) begin
          if (!settings[k][ACT_BIT]) slot = k;
        end
        if (slot >= 0) begin
          settings[slot] = s;
          pins[slot] = req.pin;
        end
      end
      refresh_top();
    endfunction

    function void apply_tick(cmd_item_t req);
      evt_item_t ev;
      int unsigned n;
      logic [2:0] e;
      logic lvl;
      bit emit;
      n = 0;
      for (int k = 0; k <= top_active && k < Entries; k++) begin
        e = settings[k][2:0];
        if (settings[k][ACT_BIT] && (req.tick_count & ((8'd1 << e) - 8'd1)) == 8'd0) begin
          emit = 1'b1;
          if (settings[k][ANA_BIT]) begin
            ev.kind = KIND_ANALOG;
            ev.level = 1'b0;
          end else begin
            lvl = req.pin_levels[pins[k]];
            if (lvl == settings[k][LVL_BIT]) begin
              emit = 1'b0;
            end else begin
              settings[k][LVL_BIT] = lvl;
              ev.kind = KIND_DIGITAL;
              ev.level = lvl;
            end
          end
          // past the cap the level still updates, nothing is emitted
          if (emit && n < ResultCap) begin
            ev.out_pin = pins[k];
            ev.last = 1'b0;
            pending_events.push_back(ev);
            n++;
          end
        end
      end
      if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void apply_clear();
      for (int k = 0; k < Entries; k++) begin
        if (!settings[k][LOC_BIT]) begin
          settings[k] = '0;
          pins[k] = '0;
        end
      end
      refresh_top();
    endfunction

    function void note_request(cmd_item_t req);
      case (req.op)
        OP_SET: apply_set(req);
        OP_TICK: apply_tick(req);
        OP_CLEAR: apply_clear();
        default: ;
      endcase
    endfunction

    function void check_event(evt_item_t got);
      evt_item_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d out_pin %0d level %0d last %0d",
               got.kind, got.out_pin, got.level, got.last);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.out_pin !== want.out_pin) begin
        $error("out_pin: expected %0d, got %0d", want.out_pin, got.out_pin);
        mismatches++;
      end
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_events.size();
    endfunction
  endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top-level bench for pin_listener_table_unit: directed and random requests with
// random stalls on both channels. Depends on pltu_pkg, pltu_stream_if, pltu_tb_pkg.

module tb;
  import pltu_pkg::*;
  import pltu_tb_pkg::*;

  localparam int unsigned RandomRequests = 380;
  localparam int unsigned CycleLimit = 1_200_000;
  localparam int unsigned DrainCycles = 40;

  logic clk;
  logic rst;

  pltu_stream_if #(.payload_t(cmd_item_t)) cmd ();
  pltu_stream_if #(.payload_t(evt_item_t)) evt ();

  pin_listener_table_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .evt(evt)
  );

  listener_table_model board;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  int unsigned sink_hold;
  int unsigned sink_gap;
  int unsigned cycles = 0;
  logic [7:0] tick_ctr = '0;
  logic [63:0] levels_now = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL pin_listener_table_unit");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // event side: after an event, ready may drop for a random gap
  always @(posedge clk) begin
    if (rst) begin
      evt.ready <= 1'b0;
      sink_hold <= 0;
    end else if (evt.ready) begin
      if (evt.valid) begin
        board.check_event(evt.data);
        sink_gap = draw_gap(sink_burst);
        if (sink_gap != 0) begin
          evt.ready <= 1'b0;
          sink_hold <= sink_gap - 1;
        end
      end
    end else if (sink_hold == 0) begin
      evt.ready <= 1'b1;
    end else begin
      sink_hold <= sink_hold - 1;
    end
  end

  function automatic cmd_item_t pack_request(logic [1:0] op, logic [5:0] pin, logic en,
                                             logic ana, logic [2:0] e, logic loc,
                                             logic [7:0] tick, logic [63:0] levels);
    cmd_item_t req;
    req.op = op;
    req.pin = pin;
    req.enable = en;
    req.analog_mode = ana;
    req.exponent = e;
    req.from_local = loc;
    req.tick_count = tick;
    req.pin_levels = levels;
    return req;
  endfunction

  task automatic send_request(input cmd_item_t req);
    int unsigned gap;
    gap = draw_gap(src_burst);
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data <= req;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    board.note_request(req);
  endtask

  // drop the request line so the last request is not taken again
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    cmd_item_t req;
    int unsigned counted;
    int unsigned sel;
    board = new();
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_request(pack_request(OP_SET, 6'd0, 1'b1, 1'b0, 3'd0, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_SET, 6'd63, 1'b1, 1'b1, 3'd7, 1'b1, 8'hff, '1));
    send_request(pack_request(OP_SET, 6'd5, 1'b1, 1'b0, 3'd1, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd0, '1));
    send_request(pack_request(OP_TICK, 6'd63, 1'b1, 1'b1, 3'd7, 1'b1, 8'd1, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd128, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd255,
                              64'h8000_0000_0000_0001));
    wait_drained();
    // remote request against a locally owned entry is dropped
    send_request(pack_request(OP_SET, 6'd63, 1'b0, 1'b0, 3'd0, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_SET, 6'd5, 1'b1, 1'b1, 3'd2, 1'b1, 8'h00, '0));
    send_request(pack_request(OP_NOP, 6'h3f, 1'b1, 1'b1, 3'd7, 1'b1, 8'hff, '1));
    send_request(pack_request(OP_CLEAR, 6'h2a, 1'b1, 1'b0, 3'd5, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd0,
                              64'h5555_aaaa_5555_aaaa));
    // wiped entries hold pin 0, so this lands on the first of them
    send_request(pack_request(OP_SET, 6'd0, 1'b1, 1'b0, 3'd3, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_SET, 6'd0, 1'b0, 1'b0, 3'd0, 1'b1, 8'h00, '0));
    send_request(pack_request(OP_SET, 6'd63, 1'b0, 1'b0, 3'd0, 1'b1, 8'h00, '0));
    send_request(pack_request(OP_SET, 6'd5, 1'b0, 1'b0, 3'd0, 1'b1, 8'h00, '0));
    send_request(pack_request(OP_CLEAR, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd0, '1));
    send_request(pack_request(OP_SET, 6'd17, 1'b1, 1'b0, 3'd0, 1'b0, 8'h00, '0));
    send_request(pack_request(OP_TICK, 6'd0, 1'b0, 1'b0, 3'd0, 1'b0, 8'd0, '1));

    // random part
    counted = 0;
    while (counted < RandomRequests) begin
      if ($urandom_range(0, 39) == 0) begin
        src_burst = ($urandom_range(0, 2) == 0);
        sink_burst = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 59) == 0) wait_drained();
      sel = $urandom_range(0, 99);
      req.pin = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
      req.enable = ($urandom_range(0, 6) != 0);
      req.analog_mode = ($urandom_range(0, 2) == 0);
      req.exponent = $urandom_range(0, 1) ? 3'($urandom_range(0, 2))
                                          : 3'($urandom_range(0, 7));
      req.from_local = ($urandom_range(0, 3) == 0);
      req.tick_count = 8'($urandom_range(0, 255));
      req.pin_levels = {$urandom(), $urandom()};
      if (sel < 45) begin
        req.op = OP_SET;
      end else if (sel < 96) begin
        req.op = OP_TICK;
        tick_ctr = tick_ctr + 8'd1;
        if ($urandom_range(0, 4) != 0) req.tick_count = tick_ctr;
        // mostly sparse level changes so digital listeners see real edges
        case ($urandom_range(0, 2))
          0: levels_now = {$urandom(), $urandom()};
          1: levels_now = levels_now ^ (64'd1 << $urandom_range(0, 63))
                                     ^ (64'd1 << $urandom_range(0, 63));
          default: ;
        endcase
        req.pin_levels = levels_now;
      end else if (sel < 98) begin
        req.op = OP_CLEAR;
      end else begin
        req.op = OP_NOP;
      end
      if (req.op != OP_NOP) counted++;
      send_request(req);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS pin_listener_table_unit");
    end else begin
      $display("FAIL pin_listener_table_unit");
    end
    $finish;
  end

endmodule

/* files.f */
design/pltu_pkg.sv
design/pltu_stream_if.sv
design/pltu_result_queue.sv
design/pin_listener_table_unit.sv
design/pltu_checker.sv
tb/pltu_tb_pkg.sv
tb/tb.sv
